/* rtl/rmq_pkg.sv */
// shared constants and types for the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 30;
	localparam int LANES          = 4;

	// which quaternion component carries the square root
	typedef enum logic [1:0] {
		LG_X = 2'd0,
		LG_Y = 2'd1,
		LG_Z = 2'd2,
		LG_W = 2'd3
	} large_t;
endpackage

/* rtl/rmq_sqrt.sv */
// pipelined integer square root, one result bit per stage, with a carried sideband
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; #(
	parameter int XW  = 64,
	parameter int SBW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [XW-1:0]     in_x,
	input  logic [SBW-1:0]    in_sb,
	output logic              out_valid,
	output logic [XW/2-1:0]   out_root,
	output logic [SBW-1:0]    out_sb
);
	localparam int N = XW / 2;

	logic           vld_s  [1:N];
	logic [N:0]     rem_s  [1:N];
	logic [N-1:0]   root_s [1:N];
	logic [XW-1:0]  x_s    [1:N];
	logic [SBW-1:0] sb_s   [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic           cur_vld;
		logic [N:0]     cur_rem;
		logic [N-1:0]   cur_root;
		logic [XW-1:0]  cur_x;
		logic [SBW-1:0] cur_sb;
		logic [N+2:0]   rsh;
		logic [N+2:0]   trial;
		logic [N+2:0]   diff;
		logic           ge;

		if (i == 0) begin : g_first
			assign cur_vld  = in_valid;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_x    = in_x;
			assign cur_sb   = in_sb;
		end else begin : g_next
			assign cur_vld  = vld_s[i];
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_x    = x_s[i];
			assign cur_sb   = sb_s[i];
		end

		// bring down two radicand bits, try 4*root+1
		assign rsh   = {cur_rem, cur_x[XW-1 -: 2]};
		assign trial = {1'b0, cur_root, 2'b01};
		assign ge    = rsh >= trial;
		assign diff  = ge ? (rsh - trial) : rsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= diff[N:0];
				root_s[i+1] <= {cur_root[N-2:0], ge};
				x_s[i+1]    <= cur_x << 2;
				sb_s[i+1]   <= cur_sb;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N];
	assign out_sb    = sb_s[N];
endmodule

/* rtl/rmq_div.sv */
// pipelined restoring divider, four lanes over one shared divisor, one quotient bit per stage
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; #(
	parameter int QW  = 32,
	parameter int DVW = 34,
	parameter int SBW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][DVW-1:0]   in_rem,
	input  logic [LANES-1:0][QW-1:0]    in_lo,
	input  logic [DVW-1:0]              in_d,
	input  logic [SBW-1:0]              in_sb,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    out_q,
	output logic [SBW-1:0]              out_sb
);
	logic                      vld_s [1:QW];
	logic [LANES-1:0][DVW-1:0] rem_s [1:QW];
	logic [LANES-1:0][QW-1:0]  lo_s  [1:QW];
	logic [LANES-1:0][QW-1:0]  q_s   [1:QW];
	logic [DVW-1:0]            d_s   [1:QW];
	logic [SBW-1:0]            sb_s  [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic                      cur_vld;
		logic [LANES-1:0][DVW-1:0] cur_rem;
		logic [LANES-1:0][QW-1:0]  cur_lo;
		logic [LANES-1:0][QW-1:0]  cur_q;
		logic [DVW-1:0]            cur_d;
		logic [SBW-1:0]            cur_sb;
		logic [LANES-1:0][DVW-1:0] nxt_rem;
		logic [LANES-1:0][QW-1:0]  nxt_q;

		if (i == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rem = in_rem;
			assign cur_lo  = in_lo;
			assign cur_q   = '0;
			assign cur_d   = in_d;
			assign cur_sb  = in_sb;
		end else begin : g_next
			assign cur_vld = vld_s[i];
			assign cur_rem = rem_s[i];
			assign cur_lo  = lo_s[i];
			assign cur_q   = q_s[i];
			assign cur_d   = d_s[i];
			assign cur_sb  = sb_s[i];
		end

		for (genvar k = 0; k < LANES; k++) begin : g_lane
			logic [DVW:0] rsh;
			logic [DVW:0] diff;
			logic         ge;
			assign rsh  = {cur_rem[k], cur_lo[k][QW-1]};
			assign ge   = rsh >= {1'b0, cur_d};
			assign diff = ge ? (rsh - {1'b0, cur_d}) : rsh;
			assign nxt_rem[k] = diff[DVW-1:0];
			assign nxt_q[k]   = {cur_q[k][QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= nxt_rem;
				q_s[i+1]   <= nxt_q;
				for (int k = 0; k < LANES; k++) begin
					lo_s[i+1][k] <= cur_lo[k] << 1;
				end
				d_s[i+1]   <= cur_d;
				sb_s[i+1]  <= cur_sb;
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_q     = q_s[QW];
	assign out_sb    = sb_s[QW];
endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Converts a stream of 3x3 rotation matrices in signed fixed point (Q2.30 by default)
// to quaternions (x, y, z, w). One matrix is accepted every cycle while the output is
// not stalled. A matrix passes stage 1, the one-bit-per-stage square root pipeline,
// stage 2, the one-bit-per-stage divider pipeline and the output register in order.
// The whole pipeline stalls while the output word waits for m_tready.
// degenerate (m_tuser) flags a zero scale, and then all four components are zero.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2, zero fill
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// quat_x, quat_y, quat_z, quat_w, zero fill
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
	// degenerate
	output logic                                   m_tuser
);
	localparam int DW   = DATA_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int OW   = ((4*DW+7)/8)*8;
	localparam int EW   = DW + 3;
	localparam int RW   = DW + 2;
	localparam int NUMW = DW + 1;
	localparam int MAGW = DW + 1;
	localparam int NW   = MAGW + FB;
	localparam int HW   = NW - DW;
	localparam int SQW  = RW + FB;
	localparam int XW   = SQW + (SQW % 2);
	localparam int RTW  = XW / 2;
	localparam int DVW  = RTW + 1;
	localparam int MXW  = (HW > DVW) ? HW : DVW;
	localparam int SB1W = 2 + LANES*NUMW;
	localparam int SB2W = 1 + 2 + LANES + LANES + RTW;

	logic en;
	logic m_tvalid_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// ---- stage 1: trace, case choice, radicand and numerators
	logic signed [EW-1:0] m [9];
	logic signed [EW-1:0] one_e;
	logic signed [EW-1:0] tr;
	logic signed [EW-1:0] rad;
	logic signed [NUMW-1:0] one_n, d21, d02, d10, s01, s02, s12;
	logic [LANES-1:0][NUMW-1:0] num_c;
	large_t large_c;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			m[k] = EW'($signed(s_tdata[k*DW +: DW]));
		end
	end

	assign one_e = EW'(1) <<< FB;
	assign one_n = NUMW'(1) <<< FB;
	assign tr    = m[0] + m[4] + m[8];
	assign d21   = NUMW'(m[7] - m[5]);
	assign d02   = NUMW'(m[2] - m[6]);
	assign d10   = NUMW'(m[3] - m[1]);
	assign s01   = NUMW'(m[1] + m[3]);
	assign s02   = NUMW'(m[2] + m[6]);
	assign s12   = NUMW'(m[5] + m[7]);

	always_comb begin
		if (tr > 0) begin
			large_c = LG_W;
			rad     = tr + one_e;
			num_c   = {one_n, d10, d02, d21};
		end else if (m[4] < m[0] && m[8] < m[0]) begin
			large_c = LG_X;
			rad     = one_e + m[0] - m[4] - m[8];
			num_c   = {d21, s02, s01, one_n};
		end else if (m[8] < m[4]) begin
			large_c = LG_Y;
			rad     = one_e + m[4] - m[0] - m[8];
			num_c   = {d02, s12, one_n, s01};
		end else begin
			large_c = LG_Z;
			rad     = one_e + m[8] - m[0] - m[4];
			num_c   = {d10, one_n, s12, s02};
		end
	end

	logic                       valid_s1;
	logic [RW-1:0]              rad_s1;
	large_t                     large_s1;
	logic [LANES-1:0][NUMW-1:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// negative radicand clamps to zero
			rad_s1   <= rad[EW-1] ? '0 : rad[RW-1:0];
			large_s1 <= large_c;
			num_s1   <= num_c;
		end
	end

	// ---- square root of rad * 2^FB
	logic            sq_valid;
	logic [RTW-1:0]  sq_root;
	logic [SB1W-1:0] sq_sb;
	logic [XW-1:0]   sq_x;

	assign sq_x = XW'(rad_s1) << FB;

	rmq_sqrt #(.XW(XW), .SBW(SB1W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.in_x     (sq_x),
		.in_sb    ({large_s1, num_s1}),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_sb   (sq_sb)
	);

	// ---- stage 2: scale, magnitudes, overflow check, divider setup
	logic [LANES-1:0][NUMW-1:0] sq_num;
	large_t                     sq_large;
	logic [DVW-1:0]             scale;
	logic [LANES-1:0]           sgn_c, ovf_c;
	logic [LANES-1:0][DVW-1:0]  rem0_c;
	logic [LANES-1:0][DW-1:0]   lo_c;

	assign sq_num   = sq_sb[LANES*NUMW-1:0];
	assign sq_large = large_t'(sq_sb[SB1W-1 -: 2]);
	assign scale    = {sq_root, 1'b0};

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			logic [MAGW-1:0] mag;
			logic [NW-1:0]   dvd;
			logic [MXW-1:0]  hi;
			sgn_c[k]  = sq_num[k][NUMW-1];
			mag       = sgn_c[k] ? MAGW'(-$signed(sq_num[k])) : MAGW'(sq_num[k]);
			dvd       = NW'(mag) << FB;
			hi        = MXW'(dvd[NW-1:DW]);
			lo_c[k]   = dvd[DW-1:0];
			// quotient reaches 2^DW when the high part is not below the scale
			ovf_c[k]  = hi >= MXW'(scale);
			rem0_c[k] = hi[DVW-1:0];
		end
	end

	logic                      valid_s2;
	logic [LANES-1:0][DVW-1:0] rem0_s2;
	logic [LANES-1:0][DW-1:0]  lo_s2;
	logic [DVW-1:0]            scale_s2;
	logic [SB2W-1:0]           sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem0_s2  <= rem0_c;
			lo_s2    <= lo_c;
			scale_s2 <= scale;
			sb_s2    <= {(sq_root == '0), sq_large, sgn_c, ovf_c, RTW'(sq_root >> 1)};
		end
	end

	// ---- divide by the scale
	logic                     dv_valid;
	logic [LANES-1:0][DW-1:0] dv_q;
	logic [SB2W-1:0]          dv_sb;

	rmq_div #(.QW(DW), .DVW(DVW), .SBW(SB2W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s2),
		.in_rem   (rem0_s2),
		.in_lo    (lo_s2),
		.in_d     (scale_s2),
		.in_sb    (sb_s2),
		.out_valid(dv_valid),
		.out_q    (dv_q),
		.out_sb   (dv_sb)
	);

	// ---- output stage: pick, saturate, sign
	logic                     dv_deg;
	large_t                   dv_large;
	logic [LANES-1:0]         dv_sgn, dv_ovf;
	logic [RTW-1:0]           dv_half;
	logic [LANES-1:0][DW-1:0] res_c;
	logic [DW-1:0]            max_pos, min_neg;

	assign dv_half  = dv_sb[RTW-1:0];
	assign dv_ovf   = dv_sb[RTW +: LANES];
	assign dv_sgn   = dv_sb[RTW+LANES +: LANES];
	assign dv_large = large_t'(dv_sb[RTW+2*LANES +: 2]);
	assign dv_deg   = dv_sb[SB2W-1];
	assign max_pos  = {1'b0, {(DW-1){1'b1}}};
	assign min_neg  = {1'b1, {(DW-1){1'b0}}};

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (dv_deg) begin
				res_c[k] = '0;
			end else if (k == int'(dv_large)) begin
				res_c[k] = ((RTW+1)'(dv_half) > (RTW+1)'(max_pos)) ? max_pos
					: DW'(dv_half);
			end else if (dv_ovf[k]) begin
				res_c[k] = dv_sgn[k] ? min_neg : max_pos;
			end else if (dv_sgn[k]) begin
				res_c[k] = (dv_q[k] > min_neg) ? min_neg : (-dv_q[k]);
			end else begin
				res_c[k] = (dv_q[k] > max_pos) ? max_pos : dv_q[k];
			end
		end
	end

	logic [LANES-1:0][DW-1:0] res_q;
	logic                     deg_q;
	large_t                   large_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= res_c;
			deg_q   <= dv_deg;
			large_q <= dv_large;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OW'(res_q);
	assign m_tuser  = deg_q;

`ifndef NO_ASSERTIONS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> res_q == '0)
		else $error("degenerate word carries nonzero components");

	a_large_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !res_q[large_q][DW-1])
		else $error("root component came out negative");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(res_q) && $stable(deg_q))
		else $error("output word changed during stall");
`endif
endmodule
